// ===== design/request_frame_replay_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the request frame replay filter
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef REQUEST_FRAME_REPLAY_FILTER_MACROS_SVH
`define REQUEST_FRAME_REPLAY_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rfrf_pkg.sv =====
// ----------------------------------------------------------------------------
// rfrf_pkg
// Types and constants shared by the request frame replay filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rfrf_pkg;

  localparam int DEFAULT_REPLAY_DEPTH = 64;

  localparam logic [7:0] MAGIC_FIRST    = 8'h69;
  localparam logic [7:0] MAGIC_SECOND   = 8'h6B;
  localparam logic [7:0] NONCE_LAST_POS = 8'd5;
  localparam logic [7:0] POS_MAX        = 8'hFF;

  // Word index of the only register, taken from paddr[2].
  localparam logic REG_XOR_KEY = 1'b0;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_BAD_MAGIC = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_e;

  typedef enum logic {
    T_IDLE = 1'b0,
    T_SCAN = 1'b1
  } top_state_e;

  typedef enum logic [1:0] {
    W_IDLE = 2'd0,
    W_SCAN = 2'd1,
    W_PUSH = 2'd2
  } win_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] nonce;
  } win_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } win_rsp_t;

endpackage

`default_nettype wire

// ===== design/rfrf_ram.sv =====
// ----------------------------------------------------------------------------
// rfrf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrf_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/rfrf_window.sv =====
// ----------------------------------------------------------------------------
// rfrf_window
// FIFO window of recent nonces: scans held entries one per cycle through a
// shared comparator and, if none matches, appends the fresh nonce, evicting the oldest when full.
// ----------------------------------------------------------------------------
`default_nettype none

module rfrf_window
  import rfrf_pkg::*;
#(
  parameter int REPLAY_DEPTH = DEFAULT_REPLAY_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire win_req_t req_i,
  output win_rsp_t      rsp_o
);

  localparam int AW = (REPLAY_DEPTH > 1) ? $clog2(REPLAY_DEPTH) : 1;
  localparam int CW = $clog2(REPLAY_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(REPLAY_DEPTH - 1);
  localparam logic [CW-1:0] FULL      = CW'(REPLAY_DEPTH);

  win_state_e    state_q, state_d;
  logic [AW-1:0] oldest_q, oldest_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] scan_ptr_q, scan_ptr_d;
  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] issued_q, issued_d;
  logic          cmp_v_q, cmp_v_d;
  logic [31:0]   nonce_q, nonce_d;

  logic          issue;
  logic          hit;
  logic [31:0]   rd_data;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // The read issued in one cycle is compared in the next.
  assign issue = (state_q == W_SCAN) && (issued_q != held_q);
  assign hit   = cmp_v_q && (rd_data == nonce_q);

  rfrf_ram #(
    .WIDTH (32),
    .DEPTH (REPLAY_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == W_PUSH),
    .waddr_i (tail_q),
    .wdata_i (nonce_q),
    .re_i    (issue),
    .raddr_i (scan_ptr_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      W_IDLE: begin
        if (req_i.start) state_d = W_SCAN;
      end
      W_SCAN: begin
        if (hit) begin
          state_d = W_IDLE;
        end else if (!issue && !cmp_v_q) begin
          state_d = W_PUSH;
        end
      end
      W_PUSH:  state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = ((state_q == W_SCAN) && hit) || (state_q == W_PUSH);
    rsp_o.hit  = (state_q == W_SCAN) && hit;
  end

  always_comb begin
    oldest_d   = oldest_q;
    tail_d     = tail_q;
    held_d     = held_q;
    scan_ptr_d = scan_ptr_q;
    issued_d   = issued_q;
    nonce_d    = nonce_q;
    cmp_v_d    = issue;
    if ((state_q == W_IDLE) && req_i.start) begin
      nonce_d    = req_i.nonce;
      scan_ptr_d = oldest_q;
      issued_d   = '0;
    end
    if (issue) begin
      scan_ptr_d = next_slot(scan_ptr_q);
      issued_d   = issued_q + 1'b1;
    end
    // When the window is full the tail sits on the oldest entry.
    if (state_q == W_PUSH) begin
      tail_d = next_slot(tail_q);
      if (held_q == FULL) begin
        oldest_d = next_slot(oldest_q);
      end else begin
        held_d = held_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= W_IDLE;
      oldest_q   <= '0;
      tail_q     <= '0;
      held_q     <= '0;
      scan_ptr_q <= '0;
      issued_q   <= '0;
      cmp_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      oldest_q   <= oldest_d;
      tail_q     <= tail_d;
      held_q     <= held_d;
      scan_ptr_q <= scan_ptr_d;
      issued_q   <= issued_d;
      cmp_v_q    <= cmp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nonce_q <= nonce_d;
  end

endmodule

`default_nettype wire

// ===== design/request_frame_replay_filter.sv =====
// ----------------------------------------------------------------------------
// request_frame_replay_filter
// Checks frame magic, descrambles bytes, rejects replayed nonces and passes
// the body bytes of accepted frames.
// ----------------------------------------------------------------------------
// Frame bytes enter on the in channel (data_byte_i, is_last_i) one word per
// handshake. Each word that carries a body byte, or that ends a frame, gives
// one word on the out channel; other words give nothing. The key is to be
// written over the APB port while the block is idle; the block does not check.
// A word that needs no nonce check has its result in the output register
// from the next cycle on. The byte completing the nonce of a frame with good
// magic holds the input back while the window unit, which holds up to
// REPLAY_DEPTH nonces, checks it: the unit reads the nonce RAM one entry per
// cycle into a single comparator, compares each entry after its read and,
// once the scan has drained, appends the fresh nonce. A duplicate ends the
// scan as soon as it is found, and no nonce is appended.
// A new word is taken while the output register is empty or being drained
// in the same cycle, so a stalled receiver holds the input back after one
// pending result. Reset empties the window and clears the frame state and
// the key; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module request_frame_replay_filter
  import rfrf_pkg::*;
#(
  parameter int REPLAY_DEPTH = DEFAULT_REPLAY_DEPTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  body_byte_o,
  output logic             has_byte_o,
  output logic             frame_end_o,
  output logic      [1:0]  verdict_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  top_state_e  state_q, state_d;
  logic [7:0]  pos_q, pos_d;
  status_e     status_q, status_d;
  logic [31:0] nonce_q, nonce_d;
  logic        pend_last_q, pend_last_d;
  logic [7:0]  xor_key_q, xor_key_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  body_q, body_d;
  logic        has_q, has_d;
  logic        end_q, end_d;
  logic [1:0]  verdict_q, verdict_d;

  logic        in_fire;
  logic        cfg_write;
  logic        defer;
  logic        emit;
  logic [7:0]  plain;
  status_e     status_new;
  logic [31:0] nonce_new;
  status_e     verdict;
  win_req_t    win_req;
  win_rsp_t    win_rsp;

  assign in_ready_o = (state_q == T_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign plain      = data_byte_i ^ xor_key_q;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign prdata    = (paddr[2] == REG_XOR_KEY) ? {24'h0, xor_key_q} : 32'h0;
  assign xor_key_d = (cfg_write && (paddr[2] == REG_XOR_KEY)) ? pwdata[7:0] : xor_key_q;

  assign out_valid_o = out_valid_q;
  assign body_byte_o = body_q;
  assign has_byte_o  = has_q;
  assign frame_end_o = end_q;
  assign verdict_o   = verdict_q;

  rfrf_window #(
    .REPLAY_DEPTH (REPLAY_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (win_req),
    .rsp_o  (win_rsp)
  );

  // Byte decode for the word being accepted.
  always_comb begin
    status_new = status_q;
    nonce_new  = nonce_q;
    defer      = 1'b0;
    emit       = 1'b0;
    if (pos_q == 8'd0) begin
      if (data_byte_i != MAGIC_FIRST) status_new = ST_BAD_MAGIC;
    end else if (pos_q == 8'd1) begin
      if (data_byte_i != MAGIC_SECOND) status_new = ST_BAD_MAGIC;
    end else if (pos_q <= NONCE_LAST_POS) begin
      nonce_new = {plain, nonce_q[31:8]};
      defer     = (pos_q == NONCE_LAST_POS) && (status_q == ST_ACCEPTED);
    end else begin
      emit = (status_q == ST_ACCEPTED);
    end
    if ((status_new == ST_ACCEPTED) && (pos_q < NONCE_LAST_POS)) begin
      verdict = ST_TOO_SHORT;
    end else begin
      verdict = status_new;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: begin
        if (in_fire && defer) state_d = T_SCAN;
      end
      T_SCAN: begin
        if (win_rsp.done) state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    pos_d         = pos_q;
    status_d      = status_q;
    nonce_d       = nonce_q;
    pend_last_d   = pend_last_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    body_d        = body_q;
    has_d         = has_q;
    end_d         = end_q;
    verdict_d     = verdict_q;
    win_req.start = 1'b0;
    win_req.nonce = nonce_new;

    if ((state_q == T_IDLE) && in_fire) begin
      status_d = status_new;
      nonce_d  = nonce_new;
      if (defer) begin
        // The nonce check finishes the word once the window has answered.
        win_req.start = 1'b1;
        pend_last_d   = is_last_i;
      end else begin
        if (is_last_i) begin
          pos_d    = '0;
          status_d = ST_ACCEPTED;
          nonce_d  = '0;
        end else if (pos_q != POS_MAX) begin
          pos_d = pos_q + 1'b1;
        end
        if (emit || is_last_i) begin
          out_valid_d = 1'b1;
          body_d      = emit ? plain : 8'h00;
          has_d       = emit;
          end_d       = is_last_i;
          verdict_d   = is_last_i ? verdict : ST_ACCEPTED;
        end
      end
    end

    if ((state_q == T_SCAN) && win_rsp.done) begin
      if (pend_last_q) begin
        pos_d       = '0;
        status_d    = ST_ACCEPTED;
        nonce_d     = '0;
        out_valid_d = 1'b1;
        body_d      = 8'h00;
        has_d       = 1'b0;
        end_d       = 1'b1;
        verdict_d   = win_rsp.hit ? ST_DUPLICATE : ST_ACCEPTED;
      end else begin
        pos_d    = pos_q + 1'b1;
        status_d = win_rsp.hit ? ST_DUPLICATE : ST_ACCEPTED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      pos_q       <= '0;
      status_q    <= ST_ACCEPTED;
      nonce_q     <= '0;
      pend_last_q <= 1'b0;
      xor_key_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      status_q    <= status_d;
      nonce_q     <= nonce_d;
      pend_last_q <= pend_last_d;
      xor_key_q   <= xor_key_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    body_q    <= body_d;
    has_q     <= has_d;
    end_q     <= end_d;
    verdict_q <= verdict_d;
  end

endmodule

`default_nettype wire

// ===== design/rfrf_checker.sv =====
// ----------------------------------------------------------------------------
// rfrf_checker
// Port-level checks on the replay filter's result words, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "request_frame_replay_filter_macros.svh"

module rfrf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] body_byte_o,
  input wire logic       has_byte_o,
  input wire logic       frame_end_o,
  input wire logic [1:0] verdict_o
);

  // A stalled result word keeps its contents.
  `RFRF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(body_byte_o) && $stable(has_byte_o) &&
    $stable(frame_end_o) && $stable(verdict_o),
    "result word changed while stalled")

  // Every result word carries a body byte or ends a frame.
  `RFRF_ASSERT_NOW(a_out_useful, out_valid_o, has_byte_o || frame_end_o,
    "result word with neither byte nor frame end")

  `RFRF_ASSERT_NOW(a_body_zero, out_valid_o && !has_byte_o, body_byte_o == 8'h00,
    "body byte not zero without a byte")

  // A body byte is only passed on while the frame is still accepted.
  `RFRF_ASSERT_NOW(a_verdict_clean, out_valid_o && (!frame_end_o || has_byte_o),
    verdict_o == 2'd0, "nonzero verdict outside an accepted frame end")

endmodule

bind request_frame_replay_filter rfrf_checker u_rfrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .body_byte_o (body_byte_o),
  .has_byte_o  (has_byte_o),
  .frame_end_o (frame_end_o),
  .verdict_o   (verdict_o)
);

`default_nettype wire
